// ----- rtl/core/accsup_pkg.sv -----
// Package for the acceleration spike suppressor: widths, reset values,
// register indexes, controller states and the controller-to-datapath command.
// No dependencies.
package accsup_pkg;

   localparam int DEFAULT_TIME_WIDTH = 32;

   localparam int MOVE_W      = 16;
   localparam int STAMP_W     = 32;
   localparam int HOLD_W      = 10;
   localparam int THR_W       = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;

   localparam logic [HOLD_W-1:0]         HOLD_LENGTH_RESET     = 10'd60;
   localparam logic signed [MOVE_W-1:0]  REPLACEMENT_Y_RESET   = -16'sd60;
   localparam logic signed [THR_W-1:0]   ACCEL_THRESHOLD_RESET = -32'sd90000;

   // 10^12 = 5^12 * 2^12
   localparam int SCALE_FACTOR = 244140625;
   localparam int SCALE_SHIFT  = 12;

   // dt at or above 2^CLAMP_SHIFT gives |threshold * dt^2| above any scaled diff for any nonzero threshold
   localparam int CLAMP_SHIFT = 28;
   localparam int DT_EFF_W    = CLAMP_SHIFT + 1;

   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int A_W     = 46;
   localparam int SQ_W    = 2 * CLAMP_SHIFT + 1;
   localparam int SQ_LO_W = 29;
   localparam int SQ_HI_W = SQ_W - SQ_LO_W;
   localparam int LO_W    = THR_W + SQ_LO_W + 1;
   localparam int HI_W    = THR_W + SQ_HI_W + 1;
   localparam int CMP_W   = 90;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HOLD_LENGTH     = 2'd0,
      CSR_REPLACEMENT_Y   = 2'd1,
      CSR_ACCEL_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_SQUARE,
      ST_LO,
      ST_HI,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      STEP_NONE,
      STEP_SCALE,
      STEP_SQUARE,
      STEP_LO,
      STEP_HI
   } step_type;

   typedef struct packed {
      logic     capture;
      step_type step;
      logic     commit;
   } cmd_type;

endpackage

// ----- rtl/core/accsup_if.sv -----
// Valid/ready channel interfaces for moves in and results out.
// Depends on accsup_pkg.
interface accsup_req_if import accsup_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [MOVE_W-1:0] move_x;
   logic signed [MOVE_W-1:0] move_y;
   logic                     is_absolute;
   logic [STAMP_W-1:0]       time_us;

   modport source (output valid, move_x, move_y, is_absolute, time_us, input ready);
   modport sink   (input valid, move_x, move_y, is_absolute, time_us, output ready);
endinterface

interface accsup_rsp_if import accsup_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [MOVE_W-1:0] out_x;
   logic signed [MOVE_W-1:0] out_y;
   logic                     replaced;

   modport source (output valid, out_x, out_y, replaced, input ready);
   modport sink   (input valid, out_x, out_y, replaced, output ready);
endinterface

// ----- rtl/core/accsup_ctrl.sv -----
// Controller of the spike suppressor: sequences the shared multiplier,
// owns the input ready and the result valid. Depends on accsup_pkg.
module accsup_ctrl import accsup_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_is_absolute,
   output logic    req_ready,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.step    = STEP_NONE;
      cmd.commit  = 1'b0;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && !req_is_absolute) begin
               cmd.capture = 1'b1;
               state_in    = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.step = STEP_SCALE;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.step = STEP_SQUARE;
            state_in = ST_LO;
         end
         ST_LO: begin
            cmd.step = STEP_LO;
            state_in = ST_HI;
         end
         ST_HI: begin
            cmd.step = STEP_HI;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/accsup_dp.sv -----
// Datapath of the spike suppressor: registers, shared multiplier, signed
// compare and hold-off counter. Depends on accsup_pkg.
module accsup_dp import accsup_pkg::*; #(
   parameter int TIME_WIDTH = DEFAULT_TIME_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   input  logic signed [MOVE_W-1:0] move_x,
   input  logic signed [MOVE_W-1:0] move_y,
   input  logic [STAMP_W-1:0]       time_us,
   input  logic                     csr_write_en,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data,
   output logic signed [MOVE_W-1:0] out_x,
   output logic signed [MOVE_W-1:0] out_y,
   output logic                     replaced
);

   logic [HOLD_W-1:0]        hold_length_ff, hold_length_in;
   logic signed [MOVE_W-1:0] replacement_y_ff, replacement_y_in;
   logic signed [THR_W-1:0]  accel_threshold_ff, accel_threshold_in;
   logic signed [MOVE_W-1:0] last_y_ff, last_y_in;
   logic [TIME_WIDTH-1:0]    last_time_ff, last_time_in;
   logic [HOLD_W-1:0]        hold_ff, hold_in;

   logic signed [MOVE_W-1:0] x_ff, y_ff, out_x_ff, out_y_ff, out_y_in;
   logic [TIME_WIDTH-1:0]    now_ff;
   logic                     replaced_ff, replaced_in;
   logic signed [A_W-1:0]    a_ff;
   logic [SQ_W-1:0]          sq_ff;
   logic signed [LO_W-1:0]   lo_ff;
   logic signed [HI_W-1:0]   hi_ff;

   logic [TIME_WIDTH+STAMP_W-1:0]   time_wide;
   logic [TIME_WIDTH-1:0]           dt;
   logic [TIME_WIDTH+CLAMP_SHIFT:0] dt_wide;
   logic                            dt_big, dt_zero;
   logic [DT_EFF_W-1:0]             dt_eff;
   logic signed [MOVE_W:0]          diff;
   logic signed [MUL_W-1:0]         mul_a, mul_b;
   logic signed [PROD_W-1:0]        product;
   logic signed [CMP_W-1:0]         a_full, b_full;
   logic                            thr_pos, spike;

   assign time_wide = {{TIME_WIDTH{1'b0}}, time_us};
   assign dt        = now_ff - last_time_ff;
   assign dt_wide   = {{(CLAMP_SHIFT + 1){1'b0}}, dt};
   assign dt_big    = |dt_wide[TIME_WIDTH+CLAMP_SHIFT:CLAMP_SHIFT];
   assign dt_zero   = (dt == '0);
   assign dt_eff    = dt_big ? {1'b1, {CLAMP_SHIFT{1'b0}}}
                             : {1'b0, dt_wide[CLAMP_SHIFT-1:0]};
   assign diff      = {y_ff[MOVE_W-1], y_ff} - {last_y_ff[MOVE_W-1], last_y_ff};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         STEP_SCALE: begin
            mul_a = MUL_W'(diff);
            mul_b = MUL_W'(SCALE_FACTOR);
         end
         STEP_SQUARE: begin
            mul_a = MUL_W'($signed({1'b0, dt_eff}));
            mul_b = MUL_W'($signed({1'b0, dt_eff}));
         end
         STEP_LO: begin
            mul_a = MUL_W'(accel_threshold_ff);
            mul_b = MUL_W'($signed({1'b0, sq_ff[SQ_LO_W-1:0]}));
         end
         STEP_HI: begin
            mul_a = MUL_W'(accel_threshold_ff);
            mul_b = MUL_W'($signed({1'b0, sq_ff[SQ_W-1:SQ_LO_W]}));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign a_full  = CMP_W'(a_ff) <<< SCALE_SHIFT;
   assign b_full  = CMP_W'(lo_ff) + (CMP_W'(hi_ff) <<< SQ_LO_W);
   assign thr_pos = !accel_threshold_ff[THR_W-1] && (accel_threshold_ff != '0);
   assign spike   = dt_zero ? thr_pos : (a_full < b_full);

   always_comb begin
      hold_length_in     = hold_length_ff;
      replacement_y_in   = replacement_y_ff;
      accel_threshold_in = accel_threshold_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_HOLD_LENGTH:     hold_length_in     = csr_write_data[HOLD_W-1:0];
            CSR_REPLACEMENT_Y:   replacement_y_in   = csr_write_data[MOVE_W-1:0];
            CSR_ACCEL_THRESHOLD: accel_threshold_in = csr_write_data[THR_W-1:0];
            default: begin
               hold_length_in = hold_length_ff;
            end
         endcase
      end
   end

   always_comb begin
      out_y_in    = y_ff;
      replaced_in = 1'b0;
      hold_in     = hold_ff;
      if (hold_ff != '0) begin
         out_y_in    = replacement_y_ff;
         replaced_in = 1'b1;
         hold_in     = hold_ff - 1'b1;
      end else if (spike) begin
         out_y_in    = replacement_y_ff;
         replaced_in = 1'b1;
         hold_in     = hold_length_ff;
      end
      last_y_in    = last_y_ff;
      last_time_in = last_time_ff;
      if (cmd.commit) begin
         last_y_in    = out_y_in;
         last_time_in = now_ff;
      end else begin
         hold_in = hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_length_ff     <= HOLD_LENGTH_RESET;
         replacement_y_ff   <= REPLACEMENT_Y_RESET;
         accel_threshold_ff <= ACCEL_THRESHOLD_RESET;
         last_y_ff          <= '0;
         last_time_ff       <= '0;
         hold_ff            <= '0;
      end else begin
         hold_length_ff     <= hold_length_in;
         replacement_y_ff   <= replacement_y_in;
         accel_threshold_ff <= accel_threshold_in;
         last_y_ff          <= last_y_in;
         last_time_ff       <= last_time_in;
         hold_ff            <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff   <= move_x;
         y_ff   <= move_y;
         now_ff <= time_wide[TIME_WIDTH-1:0];
      end
      if (cmd.step == STEP_SCALE) begin
         a_ff <= product[A_W-1:0];
      end
      if (cmd.step == STEP_SQUARE) begin
         sq_ff <= product[SQ_W-1:0];
      end
      if (cmd.step == STEP_LO) begin
         lo_ff <= product[LO_W-1:0];
      end
      if (cmd.step == STEP_HI) begin
         hi_ff <= product[HI_W-1:0];
      end
      if (cmd.commit) begin
         out_x_ff    <= x_ff;
         out_y_ff    <= out_y_in;
         replaced_ff <= replaced_in;
      end
   end

   assign out_x    = out_x_ff;
   assign out_y    = out_y_ff;
   assign replaced = replaced_ff;

endmodule

// ----- rtl/core/acceleration_spike_suppressor.sv -----
// Acceleration spike suppressor top level: controller, datapath and ports.
// Depends on accsup_pkg, accsup_if, accsup_ctrl and accsup_dp.
//
// A relative move is accepted, then steps through a single shared 33x33
// multiplier (scaled Y difference, clamped dt squared, two partial products of
// threshold times dt squared) and then the signed compare and the hold-off
// update, which wait while the result register is held full. The next move is
// taken only once the result of the last one is committed to the result
// register. An absolute move is accepted and dropped. The result register lets
// a finished result wait while the next move is accepted.
module acceleration_spike_suppressor import accsup_pkg::*; #(
   parameter int TIME_WIDTH = DEFAULT_TIME_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   accsup_req_if.sink             req_chan,
   accsup_rsp_if.source           rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   cmd_type cmd;

   accsup_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_is_absolute (req_chan.is_absolute),
      .req_ready       (req_chan.ready),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .cmd             (cmd)
   );

   accsup_dp #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .move_x         (req_chan.move_x),
      .move_y         (req_chan.move_y),
      .time_us        (req_chan.time_us),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .out_x          (rsp_chan.out_x),
      .out_y          (rsp_chan.out_y),
      .replaced       (rsp_chan.replaced)
   );

`ifndef SYNTHESIS
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && !req_chan.is_absolute |=> !req_chan.ready)
      else $error("input taken while a move is in progress");

   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !rsp_chan.valid || rsp_chan.ready)
      else $error("result overwritten before transfer");

   a_commit_not_idle: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !cmd.commit)
      else $error("commit while idle");
`endif

endmodule

// ----- tb/sv/acceleration_spike_suppressor_tb.sv -----
// Self-checking testbench for acceleration_spike_suppressor: directed and random moves,
// a clocked driver and monitor, and a scoreboard fed by an in-line spike predictor.
// Depends on accsup_pkg, accsup_if and the RTL of the block.
module acceleration_spike_suppressor_tb import accsup_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 5;
   localparam int DRAIN_CYCLES   = 12;
   localparam int LONG_STALL     = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_MOVES    = 118;
   localparam logic signed [127:0] PICO_SCALE = 128'sd1000000000000;

   typedef struct {
      logic signed [MOVE_W-1:0] x;
      logic signed [MOVE_W-1:0] y;
      logic                     absolute;
      logic [STAMP_W-1:0]       stamp;
   } move_type;

   typedef struct {
      logic signed [MOVE_W-1:0] x;
      logic signed [MOVE_W-1:0] y;
      logic                     replaced;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   accsup_req_if req_chan ();
   accsup_rsp_if rsp_chan ();

   acceleration_spike_suppressor u_top (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   move_type   pending_moves[$];
   result_type predicted_outputs[$];

   logic [HOLD_W-1:0]        cfg_hold;
   logic signed [MOVE_W-1:0] cfg_replacement;
   logic signed [THR_W-1:0]  cfg_threshold;
   logic signed [MOVE_W-1:0] last_y;
   logic [STAMP_W-1:0]       last_stamp;
   logic [HOLD_W-1:0]        hold_left;

   int  queued_count   = 0;
   int  accepted_count = 0;
   int  absolute_count = 0;
   int  results_seen   = 0;
   int  replaced_seen  = 0;
   int  mismatch_count = 0;
   int  settings_count = 0;
   int  send_gap       = 0;
   int  recv_gap       = 0;
   int  long_stall_left = 0;
   int  quiet_cycles   = 0;
   bit  long_stall_done = 1'b0;
   bit  idle_on        = 1'b1;
   bit  offer;
   bit  take;
   result_type got;
   result_type want;

   logic [STAMP_W-1:0]       gen_stamp;
   logic signed [MOVE_W-1:0] walk_y;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic bit spike_test(input logic signed [MOVE_W:0] diff,
                                     input logic [STAMP_W-1:0] dt);
      logic signed [127:0] lhs;
      logic signed [127:0] rhs;
      logic signed [127:0] wide_dt;
      logic signed [127:0] wide_thr;
      if (dt == 0) begin
         return cfg_threshold > 0;
      end
      wide_dt  = {96'd0, dt};
      wide_thr = cfg_threshold;
      lhs = diff;
      lhs = lhs * PICO_SCALE;
      rhs = wide_thr * wide_dt * wide_dt;
      return lhs < rhs;
   endfunction

   function automatic void suppress_move(input move_type m);
      result_type         r;
      logic [STAMP_W-1:0] dt;
      logic signed [MOVE_W:0] diff;
      bit                 spike;
      if (m.absolute) begin
         absolute_count++;
         return;
      end
      dt    = m.stamp - last_stamp;
      diff  = m.y;
      diff  = diff - last_y;
      spike = spike_test(diff, dt);
      r.x = m.x;
      r.y = m.y;
      r.replaced = 1'b0;
      if (hold_left != 0) begin
         r.y = cfg_replacement;
         hold_left = hold_left - 1'b1;
         r.replaced = 1'b1;
      end else if (spike) begin
         r.y = cfg_replacement;
         hold_left = cfg_hold;
         r.replaced = 1'b1;
      end
      last_stamp = m.stamp;
      last_y     = r.y;
      predicted_outputs.push_back(r);
   endfunction

   function automatic void add_move(input logic signed [MOVE_W-1:0] x,
                                    input logic signed [MOVE_W-1:0] y,
                                    input logic absolute,
                                    input logic [STAMP_W-1:0] stamp);
      move_type m;
      m.x = x;
      m.y = y;
      m.absolute = absolute;
      m.stamp = stamp;
      pending_moves.push_back(m);
      queued_count++;
   endfunction

   task automatic wait_until_drained();
      do @(posedge clock);
      while (accepted_count != queued_count || predicted_outputs.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input logic [HOLD_W-1:0] hold,
                                 input logic signed [MOVE_W-1:0] rep,
                                 input logic signed [THR_W-1:0] thr);
      wait_until_drained();
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_HOLD_LENGTH;
      csr_write_data <= CSR_DATA_W'(hold);
      @(posedge clock);
      csr_index      <= CSR_REPLACEMENT_Y;
      csr_write_data <= CSR_DATA_W'(rep);
      @(posedge clock);
      csr_index      <= CSR_ACCEL_THRESHOLD;
      csr_write_data <= CSR_DATA_W'(thr);
      @(posedge clock);
      csr_write_en   <= 1'b0;
      cfg_hold        = hold;
      cfg_replacement = rep;
      cfg_threshold   = thr;
      settings_count++;
   endtask

   task automatic run_random_phase(input logic [HOLD_W-1:0] hold,
                                   input logic signed [MOVE_W-1:0] rep,
                                   input logic signed [THR_W-1:0] thr,
                                   input bit idle);
      logic [STAMP_W-1:0]       dt;
      logic signed [MOVE_W-1:0] y;
      logic                     absolute;
      write_settings(hold, rep, thr);
      idle_on = idle;
      for (int i = 0; i < PHASE_MOVES; i++) begin
         absolute = ($urandom_range(0, 9) == 0);
         case ($urandom_range(0, 9))
            0:       dt = '0;
            1, 2:    dt = $urandom_range(1, 60);
            3, 4, 5: dt = $urandom_range(100, 4000);
            6, 7:    dt = $urandom_range(4000, 200000);
            8:       dt = $urandom;
            default: dt = $urandom_range(200000, 300000000);
         endcase
         gen_stamp = gen_stamp + dt;
         if ($urandom_range(0, 19) == 0) begin
            gen_stamp = $urandom;
         end
         case ($urandom_range(0, 7))
            0:       y = MOVE_W'($urandom);
            1:       y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: y = MOVE_W'(walk_y + $signed($urandom_range(0, 600)) - 300);
         endcase
         if (!absolute) begin
            walk_y = y;
         end
         add_move(MOVE_W'($urandom), y, absolute, gen_stamp);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            suppress_move(pending_moves.pop_front());
            accepted_count++;
         end
         if (req_chan.valid && !req_chan.ready) begin
            offer = 1'b1;
         end else if (send_gap > 0) begin
            send_gap--;
            offer = 1'b0;
         end else if (pending_moves.size() == 0) begin
            offer = 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 17);
            offer = 1'b0;
         end else begin
            offer = 1'b1;
         end
         req_chan.valid <= offer;
         if (offer) begin
            req_chan.move_x      <= pending_moves[0].x;
            req_chan.move_y      <= pending_moves[0].y;
            req_chan.is_absolute <= pending_moves[0].absolute;
            req_chan.time_us     <= pending_moves[0].stamp;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.x = rsp_chan.out_x;
            got.y = rsp_chan.out_y;
            got.replaced = rsp_chan.replaced;
            results_seen++;
            if (got.replaced) begin
               replaced_seen++;
            end
            if (predicted_outputs.size() == 0) begin
               $display("%0t: unexpected transfer x=%0d y=%0d replaced=%0b",
                        $time, got.x, got.y, got.replaced);
               mismatch_count++;
            end else begin
               want = predicted_outputs.pop_front();
               if (got.x !== want.x) begin
                  $display("%0t: out_x expected %0d got %0d", $time, want.x, got.x);
                  mismatch_count++;
               end
               if (got.y !== want.y) begin
                  $display("%0t: out_y expected %0d got %0d", $time, want.y, got.y);
                  mismatch_count++;
               end
               if (got.replaced !== want.replaced) begin
                  $display("%0t: replaced expected %0b got %0b",
                           $time, want.replaced, got.replaced);
                  mismatch_count++;
               end
            end
         end
         if (!long_stall_done && results_seen >= 300 && pending_moves.size() > 40) begin
            long_stall_left = LONG_STALL;
            long_stall_done = 1'b1;
         end
         if (long_stall_left > 0) begin
            long_stall_left--;
            take = 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            take = 1'b0;
         end else if (idle_on && $urandom_range(0, 11) == 0) begin
            recv_gap = $urandom_range(0, 17);
            take = 1'b0;
         end else begin
            take = 1'b1;
         end
         rsp_chan.ready <= take;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready) || csr_write_en) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("acceleration_spike_suppressor_tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.move_x      = '0;
      req_chan.move_y      = '0;
      req_chan.is_absolute = 1'b0;
      req_chan.time_us     = '0;
      rsp_chan.ready       = 1'b0;
      csr_write_en         = 1'b0;
      csr_index            = CSR_HOLD_LENGTH;
      csr_write_data       = '0;
      cfg_hold        = HOLD_LENGTH_RESET;
      cfg_replacement = REPLACEMENT_Y_RESET;
      cfg_threshold   = ACCEL_THRESHOLD_RESET;
      last_y     = '0;
      last_stamp = '0;
      hold_left  = '0;
      gen_stamp  = '0;
      walk_y     = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      write_settings(10'd0, 16'sd32767, -32'sd1000000);
      add_move(-16'sd32768, 16'sd12, 1'b1, 32'hffffffff);
      add_move(16'sd32767, 16'sd0, 1'b0, 32'd1000);
      add_move(-16'sd32768, -16'sd1, 1'b0, 32'd2000);
      add_move(16'sd100, -16'sd3, 1'b0, 32'd3000);
      add_move(16'sd0, 16'sd32767, 1'b0, 32'd3000);
      add_move(16'sd0, -16'sd32768, 1'b0, 32'hfffffff0);
      add_move(16'sd1, 16'sd0, 1'b0, 32'h00000010);
      add_move(16'sd2, -16'sd32768, 1'b0, 32'h00000020);

      write_settings(10'd2, -16'sd32768, 32'sd5);
      add_move(16'sd3, 16'sd10, 1'b0, 32'h00000020);
      add_move(16'sd4, 16'sd20, 1'b0, 32'h00000040);
      add_move(16'sd5, 16'sd0, 1'b1, 32'h00000000);
      add_move(16'sd6, 16'sd30, 1'b0, 32'h00000060);

      write_settings(10'd0, 16'sd0, 32'sd0);
      add_move(16'sd8, 16'sd50, 1'b0, 32'h00000060);
      add_move(16'sd9, 16'sd40, 1'b0, 32'h00000070);
      add_move(16'sd10, 16'sd45, 1'b0, 32'h00000080);
      gen_stamp = 32'h00000080;
      walk_y    = 16'sd45;

      run_random_phase(10'd60, -16'sd60, -32'sd90000, 1'b1);
      run_random_phase(10'd0, 16'sd32767, 32'sh80000000, 1'b1);
      run_random_phase(10'd1023, -16'sd32768, 32'sh7fffffff, 1'b1);
      run_random_phase(10'd3, 16'sd123, -32'sd4000000, 1'b1);
      run_random_phase(10'd1, -16'sd1, 32'sd0, 1'b1);
      run_random_phase(10'd7, 16'sd0, 32'sd100000, 1'b1);
      run_random_phase(10'd15, -16'sd500, -32'sd250000, 1'b1);
      run_random_phase(10'd2, 16'sd1000, -32'sd20000000, 1'b0);

      wait_until_drained();
      $display("moves sent: %0d (%0d absolute), results checked: %0d, replaced: %0d",
               accepted_count, absolute_count, results_seen, replaced_seen);
      $display("register settings applied: %0d, mismatches: %0d",
               settings_count, mismatch_count);
      if (mismatch_count == 0 && predicted_outputs.size() == 0) begin
         $display("acceleration_spike_suppressor_tb OK");
      end else begin
         $display("acceleration_spike_suppressor_tb NOT OK");
      end
      $finish;
   end

endmodule
